@@ src/lbc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_pkg
// Shared types, constants and helpers for the 3D Liang-Barsky clipper.
// ---------------------------------------------------------------------------
package lbc_pkg;

  localparam int NUM_BND        = 6;
  localparam int DIV_BITS       = 32;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [30:0] CLIP_EXTENT_RESET = 31'd65536;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [23:0]        start_rgb;
    logic [23:0]        end_rgb;
  } lbc_in_t;

  typedef struct packed {
    logic               segment_visible;
    logic signed [31:0] clipped_start_x;
    logic signed [31:0] clipped_start_y;
    logic signed [31:0] clipped_start_z;
    logic signed [31:0] clipped_end_x;
    logic signed [31:0] clipped_end_y;
    logic signed [31:0] clipped_end_z;
    logic [23:0]        clipped_start_rgb;
    logic [23:0]        clipped_end_rgb;
  } lbc_out_t;

  // one boundary test, before the quotient is known
  typedef struct packed {
    logic        rej;    // hard reject
    logic        act;    // narrows TE or TL
    logic        leave;  // narrows TL (else TE)
    logic        full;   // ratio is exactly one
    logic [31:0] n;
    logic [31:0] d;
  } bnd_t;

  typedef bnd_t [NUM_BND-1:0] bnd_vec_t;

  function automatic bnd_t classify(input logic signed [33:0] den,
                                    input logic signed [33:0] num);
    bnd_t             b;
    logic signed [33:0] nn;
    logic signed [33:0] dd;
    b = '0;
    nn = '0;
    dd = '0;
    if (den > 0) begin
      nn = num;
      dd = den;
      if (num > den) begin
        b.rej = 1'b1;
      end else if (num >= 0) begin
        b.act = 1'b1;
      end
    end else if (den < 0) begin
      nn = -num;
      dd = -den;
      b.leave = 1'b1;
      if (nn < 0) begin
        b.rej = 1'b1;
      end else if (nn <= dd) begin
        b.act = 1'b1;
      end
    end else begin
      b.rej = (num > 0);
    end
    b.n    = nn[31:0];
    b.d    = dd[31:0];
    b.full = b.act && (nn == dd);
    return b;
  endfunction

  // one restoring division step: remainder stays below d
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic [31:0] d);
    logic [32:0] r2;
    logic        bit_q;
    r2    = {r, 1'b0};
    bit_q = (r2 >= {1'b0, d});
    if (bit_q) begin
      r2 = r2 - {1'b0, d};
    end
    return {r2[31:0], bit_q};
  endfunction

endpackage

`default_nettype wire

@@ src/lbc_setup.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_setup
// Boundary terms and classification for the six clip planes (one stage).
// ---------------------------------------------------------------------------
module lbc_setup (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [30:0]      extent,
  input  wire lbc_pkg::lbc_in_t seg,
  output lbc_pkg::bnd_vec_t     bnd_r,
  output lbc_pkg::lbc_in_t      seg_r
);
  import lbc_pkg::*;

  logic signed [31:0] s_pt [3];
  logic signed [31:0] e_pt [3];
  bnd_vec_t           bnd_nxt;

  assign s_pt[0] = seg.start_x;
  assign s_pt[1] = seg.start_y;
  assign s_pt[2] = seg.start_z;
  assign e_pt[0] = seg.end_x;
  assign e_pt[1] = seg.end_y;
  assign e_pt[2] = seg.end_z;

  always_comb begin
    logic signed [33:0] s34;
    logic signed [33:0] d34;
    logic signed [33:0] ext34;
    ext34 = {3'b000, extent};
    for (int i = 0; i < 3; i++) begin
      s34 = {{2{s_pt[i][31]}}, s_pt[i]};
      d34 = {{2{e_pt[i][31]}}, e_pt[i]} - s34;
      bnd_nxt[2*i]   = classify(d34, -ext34 - s34);
      bnd_nxt[2*i+1] = classify(-d34, s34 - ext34);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bnd_r <= bnd_nxt;
      seg_r <= seg;
    end
  end

endmodule

`default_nettype wire

@@ src/lbc_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_div
// Pipelined restoring divider: floor(n * 2^32 / d) for n <= d.
// ---------------------------------------------------------------------------
module lbc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] n,
  input  wire logic [31:0] d,
  input  wire logic        full,
  output logic [32:0]      quot
);
  import lbc_pkg::*;

  logic [31:0] rem_r  [DIV_STAGES];
  logic [31:0] quo_r  [DIV_STAGES];
  logic [31:0] den_r  [DIV_STAGES];
  logic        full_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0] rem_nxt;
    logic [31:0] quo_nxt;
    logic [31:0] den_in;
    logic        full_in;

    if (k == 0) begin : g_first
      always_comb begin
        rem_nxt = n;
        quo_nxt = '0;
        den_in  = d;
        full_in = full;
        for (int j = 0; j < DIV_PER_STAGE; j++) begin
          logic [32:0] st;
          st      = div_step(rem_nxt, den_in);
          rem_nxt = st[32:1];
          quo_nxt = {quo_nxt[30:0], st[0]};
        end
      end
    end else begin : g_next
      always_comb begin
        rem_nxt = rem_r[k-1];
        quo_nxt = quo_r[k-1];
        den_in  = den_r[k-1];
        full_in = full_r[k-1];
        for (int j = 0; j < DIV_PER_STAGE; j++) begin
          logic [32:0] st;
          st      = div_step(rem_nxt, den_in);
          rem_nxt = st[32:1];
          quo_nxt = {quo_nxt[30:0], st[0]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        full_r[k] <= full_in;
      end
    end
  end

  assign quot = full_r[DIV_STAGES-1] ? ONE_Q32 : {1'b0, quo_r[DIV_STAGES-1]};

endmodule

`default_nettype wire

@@ src/lbc_lerp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_lerp
// s + sign(d) * round(|d| * t / 2^32); product registered, sum combinational.
// ---------------------------------------------------------------------------
module lbc_lerp (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] s,
  input  wire logic signed [31:0] e,
  input  wire logic [32:0]        t,
  output logic signed [31:0]      res
);
  import lbc_pkg::*;

  logic signed [32:0] diff;
  logic [31:0]        mag;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic               full_r;
  logic signed [31:0] s_r;
  logic signed [31:0] e_r;
  logic [64:0]        rnd;
  logic [31:0]        m;

  assign diff = {e[31], e} - {s[31], s};
  assign mag  = diff[32] ? 32'(-diff) : diff[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(mag) * 64'(t[31:0]);
      neg_r  <= diff[32];
      full_r <= t[32];
      s_r    <= s;
      e_r    <= e;
    end
  end

  assign rnd = {1'b0, prod_r} + 65'h0_8000_0000;
  assign m   = rnd[63:32];
  assign res = full_r ? e_r : (neg_r ? s_r - $signed(m) : s_r + $signed(m));

endmodule

`default_nettype wire

@@ src/line_segment_clipper_3d_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// line_segment_clipper_3d_unit
// Clips a 3D segment against the cube +/- clip_extent and interpolates colour.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one segment per transaction (in_valid / in_stall), both endpoints
//           in signed Q16.16 plus a packed RGB colour per endpoint.
//   out_* : one result per segment (out_valid / out_stall): visible flag,
//           clipped endpoints and colours at the entry and exit parameters.
//           A rejected segment gives all fields zero.
//   cfg_* : clip_extent write (cfg_valid / cfg_ready); cfg_ready is always
//           high. Write only while the pipeline is empty.
// Timing:
//   Stages in order: setup, quotient pipeline (two restoring steps per
//   stage), combine, multiply, output register.
//   Throughput is one segment per cycle unless out_stall holds a result;
//   the six boundary quotients each have their own divider pipeline.
// Reset: clears all valid bits and loads clip_extent with 1.0.
// Stall: a held result at the output freezes every stage together, so
//   in_stall follows out_stall while out_valid is high; nothing is lost.
// ---------------------------------------------------------------------------
module line_segment_clipper_3d_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lbc_pkg::lbc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lbc_pkg::lbc_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [30:0]       cfg_data
);
  import lbc_pkg::*;

  logic        en;
  logic [30:0] extent_r;

  // valid bits per stage
  logic                  v_setup_r;
  logic [DIV_STAGES-1:0] v_div_r;
  logic                  v_comb_r;
  logic                  v_lerp_r;
  logic                  out_valid_r;

  bnd_vec_t    setup_bnd;
  lbc_in_t     setup_seg;
  logic [32:0] quot [NUM_BND];

  // payload travelling beside the dividers
  lbc_in_t     dly_seg_r [DIV_STAGES];
  bnd_vec_t    dly_bnd_r [DIV_STAGES];

  // combine stage
  logic [32:0] te_nxt, tl_nxt;
  logic        vis_nxt;
  logic [32:0] te_r, tl_r;
  logic        vis_r;
  lbc_in_t     comb_seg_r;
  logic        vis_lerp_r;

  logic signed [31:0] pt_s [3];
  logic signed [31:0] pt_e [3];
  logic signed [31:0] lo_pt [3];
  logic signed [31:0] hi_pt [3];
  logic signed [31:0] lo_ch [3];
  logic signed [31:0] hi_ch [3];

  lbc_out_t out_r;
  lbc_out_t out_nxt;

  // whole pipeline moves unless a result is being held
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_r <= CLIP_EXTENT_RESET;
    end else if (cfg_valid) begin
      extent_r <= cfg_data;
    end
  end

  lbc_setup u_setup (
    .clk    (clk),
    .en     (en),
    .extent (extent_r),
    .seg    (in_data),
    .bnd_r  (setup_bnd),
    .seg_r  (setup_seg)
  );

  for (genvar b = 0; b < NUM_BND; b++) begin : g_div
    lbc_div u_div (
      .clk  (clk),
      .en   (en),
      .n    (setup_bnd[b].n),
      .d    (setup_bnd[b].d),
      .full (setup_bnd[b].full),
      .quot (quot[b])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_seg_r[0] <= setup_seg;
      dly_bnd_r[0] <= setup_bnd;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dly_seg_r[k] <= dly_seg_r[k-1];
        dly_bnd_r[k] <= dly_bnd_r[k-1];
      end
    end
  end

  // TE = max of entering ratios, TL = min of leaving ratios; the sequential
  // test rejects exactly when a hard reject occurs or TE ends above TL.
  always_comb begin
    bnd_t cur;
    te_nxt  = '0;
    tl_nxt  = ONE_Q32;
    vis_nxt = 1'b1;
    for (int b = 0; b < NUM_BND; b++) begin
      cur = dly_bnd_r[DIV_STAGES-1][b];
      if (cur.rej) begin
        vis_nxt = 1'b0;
      end
      if (cur.act && !cur.leave && quot[b] > te_nxt) begin
        te_nxt = quot[b];
      end
      if (cur.act && cur.leave && quot[b] < tl_nxt) begin
        tl_nxt = quot[b];
      end
    end
    if (te_nxt > tl_nxt) begin
      vis_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      te_r       <= te_nxt;
      tl_r       <= tl_nxt;
      vis_r      <= vis_nxt;
      comb_seg_r <= dly_seg_r[DIV_STAGES-1];
      vis_lerp_r <= vis_r;
    end
  end

  assign pt_s[0] = comb_seg_r.start_x;
  assign pt_s[1] = comb_seg_r.start_y;
  assign pt_s[2] = comb_seg_r.start_z;
  assign pt_e[0] = comb_seg_r.end_x;
  assign pt_e[1] = comb_seg_r.end_y;
  assign pt_e[2] = comb_seg_r.end_z;

  for (genvar i = 0; i < 3; i++) begin : g_lerp
    lbc_lerp u_pt_lo (
      .clk (clk), .en (en), .s (pt_s[i]), .e (pt_e[i]), .t (te_r), .res (lo_pt[i])
    );
    lbc_lerp u_pt_hi (
      .clk (clk), .en (en), .s (pt_s[i]), .e (pt_e[i]), .t (tl_r), .res (hi_pt[i])
    );
    lbc_lerp u_ch_lo (
      .clk (clk), .en (en),
      .s   ({24'd0, comb_seg_r.start_rgb[8*i +: 8]}),
      .e   ({24'd0, comb_seg_r.end_rgb[8*i +: 8]}),
      .t   (te_r), .res (lo_ch[i])
    );
    lbc_lerp u_ch_hi (
      .clk (clk), .en (en),
      .s   ({24'd0, comb_seg_r.start_rgb[8*i +: 8]}),
      .e   ({24'd0, comb_seg_r.end_rgb[8*i +: 8]}),
      .t   (tl_r), .res (hi_ch[i])
    );
  end

  // rejected segments leave as all-zero results
  always_comb begin
    out_nxt = '0;
    if (vis_lerp_r) begin
      out_nxt.segment_visible   = 1'b1;
      out_nxt.clipped_start_x   = lo_pt[0];
      out_nxt.clipped_start_y   = lo_pt[1];
      out_nxt.clipped_start_z   = lo_pt[2];
      out_nxt.clipped_end_x     = hi_pt[0];
      out_nxt.clipped_end_y     = hi_pt[1];
      out_nxt.clipped_end_z     = hi_pt[2];
      out_nxt.clipped_start_rgb = {lo_ch[2][7:0], lo_ch[1][7:0], lo_ch[0][7:0]};
      out_nxt.clipped_end_rgb   = {hi_ch[2][7:0], hi_ch[1][7:0], hi_ch[0][7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_setup_r   <= 1'b0;
      v_div_r     <= '0;
      v_comb_r    <= 1'b0;
      v_lerp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_setup_r   <= in_valid;
      v_div_r     <= {v_div_r[DIV_STAGES-2:0], v_setup_r};
      v_comb_r    <= v_div_r[DIV_STAGES-1];
      v_lerp_r    <= v_comb_r;
      out_valid_r <= v_lerp_r;
    end
  end

  // a rejected result carries no geometry or colour
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.segment_visible |->
      out_data.clipped_start_x == '0 && out_data.clipped_end_x == '0 &&
      out_data.clipped_start_rgb == '0 && out_data.clipped_end_rgb == '0)
    else $error("rejected segment with non-zero fields");

  // an item in the last internal stage always reaches the output
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_lerp_r |=> out_valid_r)
    else $error("result lost at output register");

  // a frozen pipeline keeps the held result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_r))
    else $error("held result changed");

endmodule

`default_nettype wire
